// ----- hw/rtl/dotted_version_parser_assert.svh -----
// assertion macros used by the checker file
`ifndef DOTTED_VERSION_PARSER_ASSERT_SVH
`define DOTTED_VERSION_PARSER_ASSERT_SVH

// consequent checked at the same edge as the antecedent
`define DVP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked at the edge after the antecedent
`define DVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dvp_pkg.sv -----
`default_nettype none
package dvp_pkg;

  // parse phase of the current component
  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // saturation limits of the magnitude
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [3:0]  DEC_RADIX = 4'd10;

  // result layout
  localparam int         REPORTED  = 4;
  localparam logic [2:0] COUNT_MAX = 3'd7;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [2:0]                 converted_count;
    logic [REPORTED-1:0][31:0]  value;
  } result_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dotted_version_parser.sv -----
// Dotted version parser: takes one byte of a version string per transfer and
// parses up to NUM_COMPONENTS dot-separated signed decimal components with
// leading whitespace, an optional sign and saturation to the int32 range.
// One item is taken every cycle unless in_stall is high; the item that carries
// end_of_string passes the input register and then the result register, around
// the combinational parse step (one multiply-by-ten accumulate and compare).
// A finished result waits in the result register while input keeps flowing;
// only an end-of-string item behind a stalled result holds the input side.
// Components not converted read zero.
`default_nettype none
module dotted_version_parser #(
  parameter int NUM_COMPONENTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_text_byte,
  input  logic               in_has_byte,
  input  logic               in_end_of_string,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_converted_count,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_second_value,
  output logic signed [31:0] out_third_value,
  output logic signed [31:0] out_fourth_value
);
  import dvp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_fire;
  logic    out_busy;
  logic    result_fire;
  result_t result;
  result_t out_result;

  assign in_item = '{text_byte: in_text_byte, has_byte: in_has_byte,
                     end_of_string: in_end_of_string};

  // input register
  dvp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_busy (out_busy),
    .item_fire(item_fire),
    .item     (item)
  );

  // parser state and per-byte update
  dvp_parse_core #(
    .NUM_COMPONENTS(NUM_COMPONENTS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (item_fire),
    .item       (item),
    .result_fire(result_fire),
    .result     (result)
  );

  // result register
  dvp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .result_fire(result_fire),
    .result     (result),
    .out_busy   (out_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_converted_count = out_result.converted_count;
  assign out_first_value     = out_result.value[0];
  assign out_second_value    = out_result.value[1];
  assign out_third_value     = out_result.value[2];
  assign out_fourth_value    = out_result.value[3];

endmodule
`default_nettype wire

// ----- hw/rtl/dvp_in_stage.sv -----
`default_nettype none
module dvp_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dvp_pkg::item_t in_item,
  input  logic          out_busy,
  output logic          item_fire,
  output dvp_pkg::item_t item
);
  import dvp_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  // an end-of-string item waits while the result register is still held
  assign item_fire = valid_r && !(item_r.end_of_string && out_busy);
  assign in_stall  = valid_r && !item_fire;
  assign take      = in_valid && !in_stall;
  assign item      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_fire) begin
      valid_nxt = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dvp_parse_core.sv -----
`default_nettype none
module dvp_parse_core #(
  parameter int NUM_COMPONENTS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_fire,
  input  dvp_pkg::item_t   item,
  output logic             result_fire,
  output dvp_pkg::result_t result
);
  import dvp_pkg::*;

  localparam int IW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int CW = $clog2(NUM_COMPONENTS + 1);

  phase_t          phase_r, phase_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            neg_r, neg_nxt;
  logic [31:0]     mag_r, mag_nxt;
  logic [31:0]     store_r   [NUM_COMPONENTS];
  logic [31:0]     store_nxt [NUM_COMPONENTS];

  logic [7:0]      c;
  logic [3:0]      digit;
  logic [31:0]     mag_base;
  logic [31:0]     limit;
  logic [35:0]     prod;
  logic [31:0]     mag_acc;
  logic [31:0]     signed_val;
  logic            take_digit;
  logic            more_left;
  logic [2:0]      count_out;
  logic [REPORTED-1:0][31:0] rep_value;

  // multiply-by-ten accumulate with saturation
  assign c          = item.text_byte;
  assign digit      = 4'(c - CH_ZERO);
  assign mag_base   = (phase_r == PH_DIGITS) ? mag_r : 32'd0;
  assign limit      = neg_r ? NEG_LIMIT : POS_LIMIT;
  assign prod       = 36'(mag_base) * 36'(DEC_RADIX) + 36'(digit);
  assign mag_acc    = (prod <= 36'(limit)) ? prod[31:0] : limit;
  assign signed_val = neg_r ? (32'd0 - mag_acc) : mag_acc;
  assign more_left  = ((IW + 1)'(idx_r) + (IW + 1)'(1)) < (IW + 1)'(NUM_COMPONENTS);

  // next state for one byte
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    take_digit = 1'b0;
    for (int k = 0; k < NUM_COMPONENTS; k++) begin
      store_nxt[k] = store_r[k];
    end
    if (item.has_byte) begin
      unique case (phase_r)
        PH_SPACE: begin
          if (is_white(c)) begin
            phase_nxt = PH_SPACE;
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            neg_nxt   = (c == CH_MINUS);
            phase_nxt = PH_SIGNED;
          end else if (is_digit(c)) begin
            take_digit = 1'b1;
            count_nxt  = count_r + CW'(1);
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_SIGNED: begin
          if (is_digit(c)) begin
            take_digit = 1'b1;
            count_nxt  = count_r + CW'(1);
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit(c)) begin
            take_digit = 1'b1;
          end else if ((c == CH_DOT) && more_left) begin
            idx_nxt   = idx_r + IW'(1);
            neg_nxt   = 1'b0;
            mag_nxt   = 32'd0;
            phase_nxt = PH_SPACE;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
    if (take_digit) begin
      mag_nxt          = mag_acc;
      phase_nxt        = PH_DIGITS;
      store_nxt[idx_r] = signed_val;
    end
  end

  // result built from the state after this byte
  assign count_out = (32'(count_nxt) > 32'(COUNT_MAX)) ? COUNT_MAX : 3'(count_nxt);

  for (genvar k = 0; k < REPORTED; k++) begin : g_rep
    if (k < NUM_COMPONENTS) begin : g_used
      assign rep_value[k] = store_nxt[k];
    end else begin : g_absent
      assign rep_value[k] = 32'd0;
    end
  end

  assign result      = '{converted_count: count_out, value: rep_value};
  assign result_fire = item_fire && item.end_of_string;

  // parser state, cleared at reset and after the last item of a string
  always_ff @(posedge clk) begin
    if (!rst_n || (item_fire && item.end_of_string)) begin
      phase_r <= PH_SPACE;
      idx_r   <= '0;
      count_r <= '0;
      neg_r   <= 1'b0;
      mag_r   <= 32'd0;
      for (int k = 0; k < NUM_COMPONENTS; k++) begin
        store_r[k] <= 32'd0;
      end
    end else if (item_fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      for (int k = 0; k < NUM_COMPONENTS; k++) begin
        store_r[k] <= store_nxt[k];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dvp_out_stage.sv -----
`default_nettype none
module dvp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             result_fire,
  input  dvp_pkg::result_t result,
  output logic             out_busy,
  output logic             out_valid,
  input  logic             out_stall,
  output dvp_pkg::result_t out_result
);
  import dvp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign out_busy   = valid_r && out_stall;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  // hold while stalled, drop after a transfer, load a new result
  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (result_fire) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (result_fire) begin
      result_r <= result;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dvp_checker.sv -----
`default_nettype none
`include "dotted_version_parser_assert.svh"
module dvp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [7:0]         in_text_byte,
  input wire logic               in_has_byte,
  input wire logic               in_end_of_string,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         out_converted_count,
  input wire logic signed [31:0] out_first_value,
  input wire logic signed [31:0] out_second_value,
  input wire logic signed [31:0] out_third_value,
  input wire logic signed [31:0] out_fourth_value
);

  logic         in_held;
  logic [9:0]   in_payload;
  logic         in_fire_last;
  logic         out_held;
  logic [130:0] out_payload;
  logic         none_converted;
  logic         values_zero;

  // handshake and payload views of both channels
  assign in_held        = in_valid && in_stall;
  assign in_payload     = {in_text_byte, in_has_byte, in_end_of_string};
  assign in_fire_last   = in_valid && !in_stall && in_end_of_string;
  assign out_held       = out_valid && out_stall;
  assign out_payload    = {out_converted_count, out_first_value, out_second_value,
                           out_third_value, out_fourth_value};
  assign none_converted = out_valid && (out_converted_count == 3'd0);
  assign values_zero    = (out_first_value == 32'sd0) && (out_second_value == 32'sd0) &&
                          (out_third_value == 32'sd0) && (out_fourth_value == 32'sd0);

  // a stalled input item stays offered with the same fields
  `DVP_ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(in_payload), "stalled input changed")

  // a stalled result stays offered
  `DVP_ASSERT_NEXT(a_out_hold, out_held, out_valid, "stalled result dropped")

  // a stalled result keeps its values
  `DVP_ASSERT_NEXT(a_out_stable, out_held, $stable(out_payload), "stalled result changed")

  // nothing converted means every value reads zero
  `DVP_ASSERT_SAME(a_zero_values, none_converted, values_zero, "unconverted value not zero")

  // a fresh result follows an end-of-string input transfer
  `DVP_ASSERT_SAME(a_result_origin, $rose(out_valid), $past(in_fire_last, 2), "stray result")

endmodule

bind dotted_version_parser dvp_checker u_dvp_checker (.*);
`default_nettype wire

// ----- tb/dotted_version_parser_tb.sv -----
`timescale 1ns / 100ps
module dotted_version_parser_tb;
  import dvp_pkg::*;

  localparam int NUM_COMP = 4;
  localparam int RANDOM_ITEMS = 1450;
  localparam int PHASE_ITEMS = 150;

  // one parsed version as the result channel reports it
  typedef struct packed {
    logic [2:0]       count;
    logic [3:0][31:0] val;
  } version_t;

  // directed row: one item, plus a typed expectation on end-of-string rows
  typedef struct packed {
    logic [7:0]  ch;
    logic        has;
    logic        last;
    logic        typed;
    logic [2:0]  count;
    logic [31:0] v0, v1, v2, v3;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    // end marker alone right after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    // sign with no digit, end marker on the same byte
    '{CH_MINUS, 1'b1, 1'b1, 1'b1, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    // ten nines saturate at the positive limit
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"9", 1'b1, 1'b1, 1'b1, 3'd1, POS_LIMIT, 32'd0, 32'd0, 32'd0},
    // tab, signs, an empty item, and a fifth component that is ignored
    '{CH_TAB, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"1", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{CH_DOT, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{8'hA5, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{CH_MINUS, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"2", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{CH_DOT, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{CH_PLUS, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"3", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{CH_DOT, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"4", 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{CH_DOT, 1'b1, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{"5", 1'b1, 1'b1, 1'b1, 3'd4, 32'd1, -32'sd2, 32'd3, 32'd4}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_text_byte = 8'h00;
  logic in_has_byte = 1'b0;
  logic in_end_of_string = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [2:0] out_converted_count;
  logic signed [31:0] out_first_value;
  logic signed [31:0] out_second_value;
  logic signed [31:0] out_third_value;
  logic signed [31:0] out_fourth_value;

  // parser state mirrored by the testbench
  phase_t parse_state;
  int comp_idx;
  int comps_converted;
  logic comp_negative;
  logic [31:0] comp_magnitude;
  logic [31:0] comp_values [NUM_COMP];

  version_t expected_versions [$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int strings_sent = 0;
  int results_checked = 0;

  dotted_version_parser #(.NUM_COMPONENTS(NUM_COMP)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_byte        (in_text_byte),
    .in_has_byte         (in_has_byte),
    .in_end_of_string    (in_end_of_string),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_converted_count (out_converted_count),
    .out_first_value     (out_first_value),
    .out_second_value    (out_second_value),
    .out_third_value     (out_third_value),
    .out_fourth_value    (out_fourth_value)
  );

  always #5 clk = ~clk;

  // parser state after reset and after each string
  function automatic void clear_parser();
    parse_state = PH_SPACE;
    comp_idx = 0;
    comps_converted = 0;
    comp_negative = 1'b0;
    comp_magnitude = '0;
    foreach (comp_values[k]) comp_values[k] = '0;
  endfunction

  // multiply-by-ten accumulate, clamped to the limit of the sign
  function automatic void accumulate_digit(input logic [7:0] c);
    logic [63:0] lim, d, m;
    lim = comp_negative ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
    d = 64'(c) - 64'(CH_ZERO);
    m = 64'(comp_magnitude);
    m = (m <= (lim - d) / 64'(DEC_RADIX)) ? m * 64'(DEC_RADIX) + d : lim;
    comp_magnitude = m[31:0];
    if (comp_idx < NUM_COMP) begin
      comp_values[comp_idx] = comp_negative ? 32'd0 - comp_magnitude : comp_magnitude;
    end
  endfunction

  // first digit: the component counts from here on
  function automatic void open_component(input logic [7:0] c);
    comp_magnitude = '0;
    comps_converted++;
    parse_state = PH_DIGITS;
    accumulate_digit(c);
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    bit white, digit, sign;
    white = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    digit = c inside {[CH_ZERO:CH_NINE]};
    sign = (c == CH_PLUS) || (c == CH_MINUS);
    case (parse_state)
      PH_SPACE: begin
        if (sign) begin
          comp_negative = (c == CH_MINUS);
          parse_state = PH_SIGNED;
        end else if (digit) begin
          open_component(c);
        end else if (!white) begin
          parse_state = PH_DONE;
        end
      end
      PH_SIGNED: begin
        if (digit) open_component(c);
        else parse_state = PH_DONE;
      end
      PH_DIGITS: begin
        if (digit) begin
          accumulate_digit(c);
        end else if (c == CH_DOT && comp_idx + 1 < NUM_COMP) begin
          comp_idx++;
          comp_negative = 1'b0;
          comp_magnitude = '0;
          parse_state = PH_SPACE;
        end else begin
          parse_state = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // snapshot of the string's result, then start over
  function automatic version_t finish_string();
    version_t v;
    v.count = (comps_converted > int'(COUNT_MAX)) ? COUNT_MAX : 3'(comps_converted);
    for (int k = 0; k < REPORTED; k++) begin
      v.val[k] = (k < NUM_COMP) ? comp_values[k] : '0;
    end
    clear_parser();
    return v;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // random version string: mostly well-formed, some broken or noisy
  task automatic build_version_string(ref item_t q[$]);
    string boundary [6];
    string digits;
    int n_comp, len, ws, pos;
    boundary = '{"2147483647", "2147483648", "2147483649", "99999999999999",
                 "0000000000002", "4294967296"};
    q.delete();
    if ($urandom_range(0, 39) == 0) begin
      q.push_back('{8'($urandom), 1'b0, 1'b1});
      return;
    end
    n_comp = $urandom_range(1, 5);
    for (int k = 0; k < n_comp; k++) begin
      if (k > 0) q.push_back('{CH_DOT, 1'b1, 1'b0});
      // leading whitespace
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          ws = $urandom_range(0, 5);
          q.push_back('{(ws == 5) ? CH_SPACE : 8'(CH_TAB + ws), 1'b1, 1'b0});
        end
      end
      // optional sign
      case ($urandom_range(0, 5))
        0: q.push_back('{CH_PLUS, 1'b1, 1'b0});
        1, 2: q.push_back('{CH_MINUS, 1'b1, 1'b0});
        default: ;
      endcase
      // digits, now and then a run near the saturation limits
      if ($urandom_range(0, 14) == 0) begin
        digits = boundary[$urandom_range(0, 5)];
        for (int i = 0; i < digits.len(); i++) q.push_back('{8'(digits[i]), 1'b1, 1'b0});
      end else begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
        repeat (len) q.push_back('{8'(CH_ZERO + $urandom_range(0, 9)), 1'b1, 1'b0});
      end
    end
    // broken strings: stray bytes, signs and dots
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, q.size());
        case ($urandom_range(0, 3))
          0: begin
            if (pos < q.size()) q[pos].text_byte = 8'($urandom);
            else q.push_back('{8'($urandom), 1'b1, 1'b0});
          end
          1: q.insert(pos, '{8'($urandom), 1'b1, 1'b0});
          2: q.insert(pos, '{($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS, 1'b1, 1'b0});
          default: q.insert(pos, '{CH_DOT, 1'b1, 1'b0});
        endcase
      end
    end
    // items without a byte
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) q.insert($urandom_range(0, q.size()),
                                             '{8'($urandom), 1'b0, 1'b0});
    end
    // end marker on the last byte or on an item of its own
    if ($urandom_range(0, 2) == 0) q.push_back('{8'($urandom), 1'b0, 1'b1});
    else q[q.size() - 1].end_of_string = 1'b1;
  endtask

  // drive one item and wait for its transfer
  task automatic send_item(input item_t it, input bit typed, input version_t typed_want);
    version_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= it.text_byte;
    in_has_byte <= it.has_byte;
    in_end_of_string <= it.end_of_string;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (it.has_byte) parse_char(it.text_byte);
    if (it.end_of_string) begin
      predicted = finish_string();
      expected_versions.push_back(typed ? typed_want : predicted);
      strings_sent++;
    end
  endtask

  // sender holds off until every result is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_versions.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    item_t gen_q [$];
    int mode, last_mode, random_items;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_item('{DIRECTED[i].ch, DIRECTED[i].has, DIRECTED[i].last}, DIRECTED[i].typed,
                '{DIRECTED[i].count,
                  {DIRECTED[i].v3, DIRECTED[i].v2, DIRECTED[i].v1, DIRECTED[i].v0}});
    end

    // random strings, idling pattern rotated every 150 items
    last_mode = -1;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      mode = (random_items / PHASE_ITEMS) % 4;
      if (mode != last_mode) begin
        hold_until_drained();
        case (mode)
          0: begin
            sender_idle_pct = 0;
            stall_pct = 0;
          end
          1: begin
            sender_idle_pct = 61;
            stall_pct = 0;
          end
          2: begin
            sender_idle_pct = 0;
            stall_pct = 61;
          end
          default: begin
            sender_idle_pct = 15;
            stall_pct = 15;
          end
        endcase
        last_mode = mode;
      end
      build_version_string(gen_q);
      foreach (gen_q[i]) begin
        send_item(gen_q[i], 1'b0, '0);
        if (gen_q[i].has_byte || gen_q[i].end_of_string) random_items++;
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d items in %0d strings, %0d parsed versions compared",
             items_sent, strings_sent, results_checked);
    $display("saturation, signs, whitespace, stray bytes and all idle/stall mixes exercised");
    if (error_count == 0) begin
      $display("dotted_version_parser_tb passed");
    end else begin
      $display("dotted_version_parser_tb failed");
    end
    $finish;
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result check against the oldest pending version
  always @(posedge clk) begin
    version_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_versions.size() == 0) begin
        $error("result transfer with no string pending, count %0d", out_converted_count);
        error_count++;
      end else begin
        want = expected_versions.pop_front();
        results_checked++;
        check_field("converted_count", 32'(want.count), 32'(out_converted_count));
        check_field("first_value", want.val[0], out_first_value);
        check_field("second_value", want.val[1], out_second_value);
        check_field("third_value", want.val[2], out_third_value);
        check_field("fourth_value", want.val[3], out_fourth_value);
      end
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("dotted_version_parser_tb failed");
    $finish;
  end

endmodule
